FILE: rtl/stic_pkg.sv
// Shared constants and types for the sample timer interrupt controller.
`default_nettype none

package stic_pkg;

    localparam int NUM_TIMERS  = 3;
    localparam int NUM_SOURCES = 11;

    localparam int OP_W      = 2;
    localparam int SEL_W     = 4;
    localparam int DATA_W    = 16;
    localparam int TIMER_W   = 8;
    localparam int EXP_W     = 3;
    localparam int PRESC_W   = 7;
    localparam int LEVEL_W   = 3;
    localparam int MASK_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;

    // Bit positions in the pending registers.
    localparam int SELF_BIT        = 5;
    localparam int TIMER_BIT_BASE  = 6;
    localparam int SAMPLE_DONE_BIT = 10;
    // Sources above this position share the level masks' top bit.
    localparam int CLAMP_POS       = 7;

    typedef logic [NUM_SOURCES-1:0] src_vec_t;

    // Item opcodes.
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Register selects above the timers.
    localparam logic [SEL_W-1:0] SEL_CPU_ENABLE   = 4'd3;
    localparam logic [SEL_W-1:0] SEL_CPU_PENDING  = 4'd4;
    localparam logic [SEL_W-1:0] SEL_CPU_CLEAR    = 4'd5;
    localparam logic [SEL_W-1:0] SEL_HOST_ENABLE  = 4'd6;
    localparam logic [SEL_W-1:0] SEL_HOST_PENDING = 4'd7;
    localparam logic [SEL_W-1:0] SEL_HOST_CLEAR   = 4'd8;
    localparam logic [SEL_W-1:0] SEL_ACK          = 4'd9;
    localparam logic [SEL_W-1:0] SEL_LEVEL        = 4'd10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MASK0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MASK1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MASK2 = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/stic_ifs.sv
// Channel interfaces for requests, responses and configuration writes.
`default_nettype none

interface stic_req_if
    import stic_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [SEL_W-1:0]  reg_select;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, opcode, reg_select, write_data, input ready);
    modport sink   (input valid, opcode, reg_select, write_data, output ready);
endinterface

interface stic_rsp_if
    import stic_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  read_data;
    logic               cpu_irq_active;
    logic [LEVEL_W-1:0] cpu_irq_level;
    logic               host_irq;

    modport source (output valid, read_data, cpu_irq_active, cpu_irq_level, host_irq,
                    input ready);
    modport sink   (input valid, read_data, cpu_irq_active, cpu_irq_level, host_irq,
                    output ready);
endinterface

interface stic_cfg_if
    import stic_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/sample_timer_interrupt_controller.sv
// Top level of the sample timer interrupt controller.
//
//   Channel  Direction  Carries
//   req      in         opcode, reg_select, write_data
//   rsp      out        read_data, cpu_irq_active, cpu_irq_level, host_irq
//   cfg      in         index, data (level mask registers)
//
// Every transaction is held in the input register and then updates the state and the
// response register together, so one transaction per cycle is sustained while the
// response is taken; the response is driven from the response register.
// Reset clears all timers, enable and pending registers, the latches and the masks.
// A stalled response holds the pipeline; the input register still takes one more
// transaction. Configuration writes are always ready.
`default_nettype none

module sample_timer_interrupt_controller
    import stic_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    stic_req_if.sink  req,
    stic_rsp_if.source rsp,
    stic_cfg_if.sink  cfg
);

    // Input register.
    logic              s1_valid_reg;
    logic [OP_W-1:0]   s1_opcode_reg;
    logic [SEL_W-1:0]  s1_sel_reg;
    logic [DATA_W-1:0] s1_data_reg;

    // Response register.
    logic              out_valid_reg;
    logic [DATA_W-1:0] read_data_reg, read_data_next;

    // Block state.
    logic [TIMER_W-1:0] count_reg [NUM_TIMERS];
    logic [EXP_W-1:0]   exp_reg   [NUM_TIMERS];
    logic [PRESC_W-1:0] presc_reg [NUM_TIMERS];
    logic [TIMER_W-1:0] count_next [NUM_TIMERS];
    logic [EXP_W-1:0]   exp_next   [NUM_TIMERS];
    logic [PRESC_W-1:0] presc_next [NUM_TIMERS];
    src_vec_t cpu_enable_reg, cpu_enable_next;
    src_vec_t cpu_pending_reg, cpu_pending_next;
    src_vec_t host_enable_reg, host_enable_next;
    src_vec_t host_pending_reg, host_pending_next;
    logic               cpu_latched_reg, cpu_latched_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               host_line_reg, host_line_next;
    logic [MASK_W-1:0]  mask0_reg, mask1_reg, mask2_reg;

    logic advance;

    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign rsp.valid          = out_valid_reg;
    assign rsp.read_data      = read_data_reg;
    assign rsp.cpu_irq_active = cpu_latched_reg;
    assign rsp.cpu_irq_level  = level_reg;
    assign rsp.host_irq       = host_line_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_opcode_reg <= req.opcode;
            s1_sel_reg    <= req.reg_select;
            s1_data_reg   <= req.write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_data_reg <= read_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask0_reg <= '0;
            mask1_reg <= '0;
            mask2_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_LEVEL_MASK0: mask0_reg <= cfg.data;
                CFG_LEVEL_MASK1: mask1_reg <= cfg.data;
                CFG_LEVEL_MASK2: mask2_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                count_reg[t] <= '0;
                exp_reg[t]   <= '0;
                presc_reg[t] <= '0;
            end
            cpu_enable_reg   <= '0;
            cpu_pending_reg  <= '0;
            host_enable_reg  <= '0;
            host_pending_reg <= '0;
            cpu_latched_reg  <= 1'b0;
            level_reg        <= '0;
            host_line_reg    <= 1'b0;
        end
        else if (advance)
        begin
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                count_reg[t] <= count_next[t];
                exp_reg[t]   <= exp_next[t];
                presc_reg[t] <= presc_next[t];
            end
            cpu_enable_reg   <= cpu_enable_next;
            cpu_pending_reg  <= cpu_pending_next;
            host_enable_reg  <= host_enable_next;
            host_pending_reg <= host_pending_next;
            cpu_latched_reg  <= cpu_latched_next;
            level_reg        <= level_next;
            host_line_reg    <= host_line_next;
        end
    end

    // Next state for the item in the input register. Within a tick, the CPU
    // output could be evaluated after each timer overflow; evaluating once at
    // the end gives the same level because every bit set later in the tick lies
    // above the one that would have won first.
    always_comb
    begin
        logic [TIMER_W-1:0] pcount;
        logic [TIMER_W-1:0] step;
        logic [TIMER_W-1:0] cnt;
        logic               eval_cpu;
        logic               eval_host;
        src_vec_t           active;
        logic [2:0]         pos;

        pcount    = '0;
        step      = '0;
        cnt       = '0;
        eval_cpu  = 1'b0;
        eval_host = 1'b0;
        pos       = '0;
        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            count_next[t] = count_reg[t];
            exp_next[t]   = exp_reg[t];
            presc_next[t] = presc_reg[t];
        end
        cpu_enable_next   = cpu_enable_reg;
        cpu_pending_next  = cpu_pending_reg;
        host_enable_next  = host_enable_reg;
        host_pending_next = host_pending_reg;
        cpu_latched_next  = cpu_latched_reg;
        level_next        = level_reg;
        host_line_next    = host_line_reg;
        read_data_next    = '0;

        case (s1_opcode_reg)
            OP_TICK:
            begin
                cpu_pending_next[SAMPLE_DONE_BIT] = 1'b1;
                for (int t = 0; t < NUM_TIMERS; t++)
                begin
                    pcount = {1'b0, presc_reg[t]} + TIMER_W'(1);
                    step   = TIMER_W'(1) << exp_reg[t];
                    if (pcount >= step)
                    begin
                        pcount        = '0;
                        cnt           = count_reg[t] + TIMER_W'(1);
                        count_next[t] = cnt;
                        if (cnt == '0)
                        begin
                            cpu_pending_next[TIMER_BIT_BASE + t]  = 1'b1;
                            host_pending_next[TIMER_BIT_BASE + t] = 1'b1;
                        end
                    end
                    presc_next[t] = pcount[PRESC_W-1:0];
                end
                eval_cpu  = 1'b1;
                eval_host = 1'b1;
            end
            OP_WRITE:
            begin
                for (int t = 0; t < NUM_TIMERS; t++)
                begin
                    if (s1_sel_reg == SEL_W'(t))
                    begin
                        count_next[t] = s1_data_reg[TIMER_W-1:0];
                        exp_next[t]   = s1_data_reg[TIMER_W +: EXP_W];
                        if (s1_data_reg[TIMER_W +: EXP_W] != exp_reg[t])
                        begin
                            presc_next[t] = '0;
                        end
                    end
                end
                case (s1_sel_reg)
                    SEL_CPU_ENABLE: cpu_enable_next = s1_data_reg[NUM_SOURCES-1:0];
                    SEL_CPU_PENDING:
                    begin
                        if (s1_data_reg[SELF_BIT])
                        begin
                            cpu_pending_next[SELF_BIT] = 1'b1;
                            eval_cpu = 1'b1;
                        end
                    end
                    SEL_CPU_CLEAR:
                        cpu_pending_next = cpu_pending_reg & ~s1_data_reg[NUM_SOURCES-1:0];
                    SEL_HOST_ENABLE: host_enable_next = s1_data_reg[NUM_SOURCES-1:0];
                    SEL_HOST_PENDING:
                    begin
                        if (s1_data_reg[SELF_BIT])
                        begin
                            host_pending_next[SELF_BIT] = 1'b1;
                            eval_host = 1'b1;
                        end
                    end
                    SEL_HOST_CLEAR:
                    begin
                        host_pending_next = host_pending_reg & ~s1_data_reg[NUM_SOURCES-1:0];
                        eval_host = 1'b1;
                    end
                    SEL_ACK:
                    begin
                        if (s1_data_reg[0])
                        begin
                            cpu_latched_next = 1'b0;
                            eval_cpu = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_READ:
            begin
                for (int t = 0; t < NUM_TIMERS; t++)
                begin
                    if (s1_sel_reg == SEL_W'(t))
                    begin
                        read_data_next = DATA_W'({exp_reg[t], count_reg[t]});
                    end
                end
                case (s1_sel_reg)
                    SEL_CPU_ENABLE:   read_data_next = DATA_W'(cpu_enable_reg);
                    SEL_CPU_PENDING:  read_data_next = DATA_W'(cpu_pending_reg);
                    SEL_HOST_ENABLE:  read_data_next = DATA_W'(host_enable_reg);
                    SEL_HOST_PENDING: read_data_next = DATA_W'(host_pending_reg);
                    SEL_LEVEL:        read_data_next = DATA_W'(level_reg);
                    default: ;
                endcase
            end
            default: ;
        endcase

        // Lowest enabled pending source wins; scan from the top so it lands last.
        active = cpu_enable_next & cpu_pending_next;
        for (int i = NUM_SOURCES - 1; i >= 0; i--)
        begin
            if (active[i])
            begin
                pos = (i > CLAMP_POS) ? 3'(CLAMP_POS) : 3'(i);
            end
        end
        if (eval_cpu && !cpu_latched_next && (active != '0))
        begin
            cpu_latched_next = 1'b1;
            level_next       = {mask2_reg[pos], mask1_reg[pos], mask0_reg[pos]};
        end

        if (eval_host)
        begin
            host_line_next = |(host_enable_next & host_pending_next);
        end
    end

    // The CPU output is released only by an acknowledge write with bit 0 set.
    a_latch_release: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(cpu_latched_reg) |-> $past(advance && s1_opcode_reg == OP_WRITE
            && s1_sel_reg == SEL_ACK && s1_data_reg[0]))
        else $error("cpu interrupt released without acknowledge");

    // The latch can only be set by an item that is being processed.
    a_latch_set: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cpu_latched_reg) |-> $past(advance))
        else $error("cpu interrupt latched without a transaction");

    // Every processed item produces a response in the next cycle.
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed transaction produced no response");

    // With the input register full and the response stalled, no new item enters.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("input register overrun");

endmodule

`default_nettype wire
